[hdl/sensor_command_frame_engine_assert.svh]
// ----------------------------------------------------------------------------
// sensor command frame engine assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SENSOR_COMMAND_FRAME_ENGINE_ASSERT_SVH
`define SENSOR_COMMAND_FRAME_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SCFE_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("scfe check failed");
`define SCFE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfe implication failed");
`else
`define SCFE_ASSERT(lbl, expr)
`define SCFE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[hdl/scfe_pkg.sv]
// ----------------------------------------------------------------------------
// scfe_pkg
// shared constants and types of the sensor command frame engine
// ----------------------------------------------------------------------------
package scfe_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int IDX_W       = 4;
    localparam int DATA_BYTES  = 7;
    localparam int ARG_BYTES   = 5;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] SENSOR_ID   = 8'h01;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [1:0] OP_RX   = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_SEND = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd3;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [15:0] RANGE_LOW     = 16'd2000;
    localparam logic [15:0] RANGE_HIGH    = 16'd5000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    localparam logic CFG_IDX_TIMEOUT = 1'b0;

    typedef struct packed {
        logic [1:0]                 op;
        logic [7:0]                 rx_byte;
        logic [7:0]                 cmd_byte;
        logic [ARG_BYTES-1:0][7:0]  args;
    } item_t;

    // send: cmd, five args, checksum; report: response bytes 2 to 7
    typedef struct packed {
        logic                        is_send;
        logic [1:0]                  status;
        logic [DATA_BYTES-1:0][7:0]  data;
    } job_t;

endpackage

[hdl/scfe_front.sv]
// ----------------------------------------------------------------------------
// scfe_front
// accepts items, runs the receiver and timeout, and queues jobs
// ----------------------------------------------------------------------------
module scfe_front
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] timeout_ticks,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       item,
    input  logic        q_ready,
    output logic        q_push,
    output job_t        q_job
);

    logic                  armed_reg, armed_next;
    logic [7:0]            expected_cmd_reg, expected_cmd_next;
    logic [IDX_W-1:0]      byte_count_reg, byte_count_next;
    logic [7:0]            running_sum_reg, running_sum_next;
    logic [15:0]           tick_count_reg, tick_count_next;
    logic [7:0]            store_reg [FRAME_BYTES];

    logic                  accept;
    logic                  store_we;
    logic [15:0]           tick_inc;
    logic [7:0]            tx_sum;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    // 8-bit sum of frame bytes 1 to 7 of a send
    always_comb
    begin
        tx_sum = SENSOR_ID + item.cmd_byte;
        for (int i = 0; i < ARG_BYTES; i++)
        begin
            tx_sum = tx_sum + item.args[i];
        end
    end

    assign tick_inc = (tick_count_reg == TICK_MAX) ? tick_count_reg : tick_count_reg + 16'd1;

    always_comb
    begin
        armed_next        = armed_reg;
        expected_cmd_next = expected_cmd_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        tick_count_next   = tick_count_reg;
        store_we          = 1'b0;
        q_push            = 1'b0;
        q_job             = '0;
        if (accept)
        begin
            unique case (item.op)
                OP_SEND:
                begin
                    q_push            = 1'b1;
                    q_job.is_send     = 1'b1;
                    q_job.data[0]     = item.cmd_byte;
                    for (int i = 0; i < ARG_BYTES; i++)
                    begin
                        q_job.data[i+1] = item.args[i];
                    end
                    q_job.data[6]     = 8'h00 - tx_sum;
                    armed_next        = 1'b1;
                    expected_cmd_next = item.cmd_byte;
                    byte_count_next   = '0;
                    running_sum_next  = '0;
                    tick_count_next   = '0;
                end
                OP_TICK:
                begin
                    if (armed_reg)
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= timeout_ticks)
                        begin
                            armed_next   = 1'b0;
                            q_push       = 1'b1;
                            q_job.status = STATUS_TIMEOUT;
                        end
                    end
                end
                OP_RX:
                begin
                    if (armed_reg && (byte_count_reg < IDX_W'(FRAME_BYTES)))
                    begin
                        store_we        = 1'b1;
                        byte_count_next = byte_count_reg + IDX_W'(1);
                        if ((byte_count_reg != '0) && (byte_count_reg != LAST_IDX))
                        begin
                            running_sum_next = running_sum_reg + item.rx_byte;
                        end
                        if (byte_count_reg == LAST_IDX)
                        begin
                            armed_next = 1'b0;
                            q_push     = 1'b1;
                            for (int i = 0; i < 6; i++)
                            begin
                                q_job.data[i] = store_reg[i+2];
                            end
                            // header and command check wins over the checksum
                            if ((store_reg[0] != HEADER_BYTE) ||
                                (store_reg[1] != expected_cmd_reg))
                            begin
                                q_job.status = STATUS_BAD_HDR;
                            end
                            else if (item.rx_byte != (8'h00 - running_sum_reg))
                            begin
                                q_job.status = STATUS_BAD_SUM;
                            end
                            else
                            begin
                                q_job.status = STATUS_OK;
                            end
                        end
                    end
                end
                default:
                begin
                    // unused op code: nothing to do
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            expected_cmd_reg <= '0;
            byte_count_reg   <= '0;
            running_sum_reg  <= '0;
            tick_count_reg   <= '0;
        end
        else
        begin
            armed_reg        <= armed_next;
            expected_cmd_reg <= expected_cmd_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
            tick_count_reg   <= tick_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[byte_count_reg] <= item.rx_byte;
        end
    end

endmodule

[hdl/scfe_queue.sv]
// ----------------------------------------------------------------------------
// scfe_queue
// two-entry job queue between the front and back parts
// ----------------------------------------------------------------------------
module scfe_queue
    import scfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  job_t  push_job,
    output logic  ready,
    input  logic  pop,
    output logic  head_valid,
    output job_t  head_job
);

    job_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign ready      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hdl/scfe_back.sv]
// ----------------------------------------------------------------------------
// scfe_back
// expands queued jobs into frame bytes and finished reports
// ----------------------------------------------------------------------------
`include "sensor_command_frame_engine_assert.svh"

module scfe_back
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [7:0]  out_tx_byte,
    output logic        out_last,
    output logic [1:0]  out_status,
    output logic [15:0] out_word_high,
    output logic [15:0] out_word_low,
    output logic        out_range_ok,
    output logic        out_flag_bit
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic             kind_reg, kind_next;
    logic [7:0]       tx_reg, tx_next;
    logic             last_reg, last_next;
    logic [1:0]       status_reg, status_next;
    logic [15:0]      high_reg, high_next;
    logic [15:0]      low_reg, low_next;
    logic             rok_reg, rok_next;
    logic             flag_reg, flag_next;

    logic             load;
    logic [7:0]       frame_byte;

    assign load = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        unique case (idx_reg)
            4'd0:    frame_byte = HEADER_BYTE;
            4'd1:    frame_byte = SENSOR_ID;
            4'd2:    frame_byte = q_job.data[0];
            4'd3:    frame_byte = q_job.data[1];
            4'd4:    frame_byte = q_job.data[2];
            4'd5:    frame_byte = q_job.data[3];
            4'd6:    frame_byte = q_job.data[4];
            4'd7:    frame_byte = q_job.data[5];
            4'd8:    frame_byte = q_job.data[6];
            default: frame_byte = '0;
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        q_pop       = 1'b0;
        kind_next   = KIND_DONE;
        tx_next     = '0;
        last_next   = 1'b0;
        status_next = q_job.status;
        high_next   = {q_job.data[0], q_job.data[1]};
        low_next    = {q_job.data[2], q_job.data[3]};
        rok_next    = (low_next == RANGE_LOW) || (low_next == RANGE_HIGH);
        flag_next   = q_job.data[5][0];
        if (q_job.is_send)
        begin
            kind_next   = KIND_TX;
            tx_next     = frame_byte;
            last_next   = (idx_reg == LAST_IDX);
            status_next = STATUS_OK;
            high_next   = '0;
            low_next    = '0;
            rok_next    = 1'b0;
            flag_next   = 1'b0;
            if (load)
            begin
                q_pop    = (idx_reg == LAST_IDX);
                idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
            end
        end
        else
        begin
            q_pop = load;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            tx_reg     <= tx_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            rok_reg    <= rok_next;
            flag_reg   <= flag_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_kind      = kind_reg;
    assign out_tx_byte   = tx_reg;
    assign out_last      = last_reg;
    assign out_status    = status_reg;
    assign out_word_high = high_reg;
    assign out_word_low  = low_reg;
    assign out_range_ok  = rok_reg;
    assign out_flag_bit  = flag_reg;

    `SCFE_ASSERT(a_idx_range, idx_reg <= LAST_IDX)
    `SCFE_ASSERT_IMP(a_idx_send_only, idx_reg != '0, q_valid && q_job.is_send)
    `SCFE_ASSERT_IMP(a_last_pops, load && q_job.is_send && (idx_reg == LAST_IDX), q_pop)
    `SCFE_ASSERT_IMP(a_report_no_last, valid_reg && (kind_reg == KIND_DONE), !last_reg)

endmodule

[hdl/sensor_command_frame_engine.sv]
// ----------------------------------------------------------------------------
// sensor_command_frame_engine
// nine-byte serial command frame engine with negated-sum checksum
// ----------------------------------------------------------------------------
// path: a request's first result is written into the job queue, then loaded into the
//   output register that drives m_tvalid
// flow: one input request per cycle while the two-entry job queue has room; a send
//   occupies the back part for nine output bytes, a report or timeout for one
// reset (rst_n low, asynchronous): receiver disarmed, counters and sum cleared,
//   job queue and output register empty, timeout_ticks back to 100
module sensor_command_frame_engine
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_byte, cmd_byte, arg_three, arg_four, arg_five, arg_six, arg_seven
    input  logic [55:0] s_tdata,
    // op
    input  logic [1:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte, status, word_high, word_low, range_ok, flag_bit, zero pad
    output logic [47:0] m_tdata,
    // kind
    output logic [0:0]  m_tuser,
    // last
    output logic        m_tlast,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] timeout_reg, timeout_next;
    logic        cfg_write;

    item_t       item;
    logic        q_ready, q_push, q_pop, q_valid;
    job_t        push_job, head_job;

    logic        out_kind, out_last, out_range_ok, out_flag_bit;
    logic [7:0]  out_tx_byte;
    logic [1:0]  out_status;
    logic [15:0] out_word_high, out_word_low;

    // configuration: one register, timeout_ticks at byte address 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_write && (paddr[2] == CFG_IDX_TIMEOUT))
        begin
            timeout_next = pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // unpack the input request
    always_comb
    begin
        item.op       = s_tuser;
        item.rx_byte  = s_tdata[7:0];
        item.cmd_byte = s_tdata[15:8];
        for (int i = 0; i < ARG_BYTES; i++)
        begin
            item.args[i] = s_tdata[16 + 8*i +: 8];
        end
    end

    // front part: receiver state, timeout and job building
    scfe_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .item          (item),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    // short queue so front and back stall on their own
    scfe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    // back part: frame serialiser and report formatter with output register
    scfe_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (out_kind),
        .out_tx_byte   (out_tx_byte),
        .out_last      (out_last),
        .out_status    (out_status),
        .out_word_high (out_word_high),
        .out_word_low  (out_word_low),
        .out_range_ok  (out_range_ok),
        .out_flag_bit  (out_flag_bit)
    );

    // pack the result request
    assign m_tdata = {4'd0, out_flag_bit, out_range_ok, out_word_low, out_word_high,
                      out_status, out_tx_byte};
    assign m_tuser = out_kind;
    assign m_tlast = out_last;

endmodule

[tb/sv/scfe_frame_checker.sv]
// ----------------------------------------------------------------------------
// scfe_frame_checker
// watches the request, output and configuration channels of the frame
// engine, predicts every output from the requests it sees and compares
// ----------------------------------------------------------------------------
module scfe_frame_checker
    import scfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        close_out,
    output int          pending,
    output int          fail_count,
    output int          outputs_seen
);

    localparam logic [2:0] TIMEOUT_ADDR = 3'(4 * CFG_IDX_TIMEOUT);

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [15:0] word_high;
        logic [15:0] word_low;
        logic        range_ok;
        logic        flag_bit;
    } engine_out_t;

    engine_out_t due_outputs[$];

    // own copy of the engine state
    logic [15:0] timeout_reg;
    logic        armed;
    logic [7:0]  want_cmd;
    int unsigned rx_count;
    logic [7:0]  reply_bytes [FRAME_BYTES];
    logic [7:0]  rx_sum;
    logic [15:0] tick_count;

    int errors = 0;
    int seen   = 0;
    bit closed = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s got %0h wanted %0h", $realtime, what, got, want);
    endtask

    function automatic engine_out_t done_output(input logic [1:0] status,
                                                input logic [15:0] hi,
                                                input logic [15:0] lo,
                                                input logic flag);
        engine_out_t o;
        o           = '0;
        o.kind      = KIND_DONE;
        o.status    = status;
        o.word_high = hi;
        o.word_low  = lo;
        o.range_ok  = (lo == RANGE_LOW) || (lo == RANGE_HIGH);
        o.flag_bit  = flag;
        return o;
    endfunction

    task automatic clear_receiver();
        armed      = 1'b0;
        rx_count   = 0;
        rx_sum     = '0;
        tick_count = '0;
        for (int i = 0; i < FRAME_BYTES; i++)
            reply_bytes[i] = '0;
    endtask

    task automatic predict_request(input logic [1:0] op, input logic [55:0] data);
        engine_out_t o;
        logic [7:0]  frame [FRAME_BYTES];
        logic [7:0]  sum;
        logic [1:0]  status;
        case (op)
            OP_SEND:
            begin
                frame[0] = HEADER_BYTE;
                frame[1] = SENSOR_ID;
                for (int i = 0; i < 6; i++)
                    frame[2 + i] = data[8 + 8 * i +: 8];
                sum = '0;
                for (int i = 1; i < 8; i++)
                    sum = sum + frame[i];
                frame[8] = 8'h00 - sum;
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    o         = '0;
                    o.kind    = KIND_TX;
                    o.tx_byte = frame[i];
                    o.last    = (i == FRAME_BYTES - 1);
                    due_outputs.push_back(o);
                end
                clear_receiver();
                want_cmd = frame[2];
                armed    = 1'b1;
            end
            OP_TICK:
            begin
                if (armed)
                begin
                    if (tick_count != TICK_MAX)
                        tick_count = tick_count + 16'd1;
                    if (tick_count >= timeout_reg)
                    begin
                        armed = 1'b0;
                        due_outputs.push_back(done_output(STATUS_TIMEOUT, '0, '0, 1'b0));
                    end
                end
            end
            OP_RX:
            begin
                if (armed && rx_count < FRAME_BYTES)
                begin
                    reply_bytes[rx_count] = data[7:0];
                    if (rx_count >= 1 && rx_count <= 7)
                        rx_sum = rx_sum + data[7:0];
                    rx_count++;
                    if (rx_count == FRAME_BYTES)
                    begin
                        armed = 1'b0;
                        // header and command check wins over the checksum
                        if (reply_bytes[0] != HEADER_BYTE || reply_bytes[1] != want_cmd)
                            status = STATUS_BAD_HDR;
                        else if (reply_bytes[8] != 8'h00 - rx_sum)
                            status = STATUS_BAD_SUM;
                        else
                            status = STATUS_OK;
                        due_outputs.push_back(done_output(status,
                            {reply_bytes[2], reply_bytes[3]},
                            {reply_bytes[4], reply_bytes[5]}, reply_bytes[7][0]));
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_output();
        engine_out_t got;
        engine_out_t want;
        got.kind      = m_tuser[0];
        got.tx_byte   = m_tdata[7:0];
        got.last      = m_tlast;
        got.status    = m_tdata[9:8];
        got.word_high = m_tdata[25:10];
        got.word_low  = m_tdata[41:26];
        got.range_ok  = m_tdata[42];
        got.flag_bit  = m_tdata[43];
        seen++;
        if (due_outputs.size() == 0)
        begin
            report_mismatch("output with nothing due, tdata", m_tdata[31:0], '0);
            return;
        end
        want = due_outputs.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.tx_byte != want.tx_byte)
            report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
        if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.word_high != want.word_high)
            report_mismatch("word_high", 32'(got.word_high), 32'(want.word_high));
        if (got.word_low != want.word_low)
            report_mismatch("word_low", 32'(got.word_low), 32'(want.word_low));
        if (got.range_ok != want.range_ok)
            report_mismatch("range_ok", 32'(got.range_ok), 32'(want.range_ok));
        if (got.flag_bit != want.flag_bit)
            report_mismatch("flag_bit", 32'(got.flag_bit), 32'(want.flag_bit));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg = TIMEOUT_RESET;
            want_cmd    = '0;
            clear_receiver();
            due_outputs.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == TIMEOUT_ADDR)
            begin
                if (pwrite)
                    timeout_reg = pwdata[15:0];
                else if (prdata != {16'h0000, timeout_reg})
                    report_mismatch("timeout_ticks read", prdata, {16'h0000, timeout_reg});
            end
            // outputs before requests: a request taken now cannot show yet
            if (m_tvalid && m_tready)
                check_output();
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            if (close_out && !closed)
            begin
                closed = 1'b1;
                if (due_outputs.size() != 0)
                    report_mismatch("outputs never delivered", due_outputs.size(), 0);
            end
            pending <= due_outputs.size();
        end
        fail_count   <= errors;
        outputs_seen <= seen;
    end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the sensor command frame engine: directed frames
// first, then random command and reply sequences under several timeouts,
// with random idling on both streams; the checker does all comparing
// ----------------------------------------------------------------------------
module tb_top;
    import scfe_pkg::*;

    localparam logic [2:0] TIMEOUT_ADDR = 3'(4 * CFG_IDX_TIMEOUT);
    localparam int MAX_IDLE     = 15;
    localparam int SETTLE       = 4;    // a little over the engine latency
    localparam int PHASE_LENGTH = 18;   // requests per random phase

    // every input known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [55:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OP_RX;
    logic        m_tready  = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        close_out = 1'b0;

    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int fail_count;
    int outputs_seen;

    // when set, neither side idles: back-to-back stretches
    bit          quiet       = 1'b0;
    int          requests    = 0;
    int          commands    = 0;
    logic [15:0] timeout_now = TIMEOUT_RESET;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sensor_command_frame_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // rx_byte, cmd_byte, arg_three .. arg_seven
        .s_tuser  (s_tuser),    // op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // tx_byte, status, word_high, word_low, range_ok, flag_bit
        .m_tuser  (m_tuser),    // kind
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    scfe_frame_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .close_out    (close_out),
        .pending      (pending),
        .fail_count   (fail_count),
        .outputs_seen (outputs_seen)
    );

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #(8 * 1000000);
        $display("FAIL");
        $finish;
    end

    // output side: a fresh stall before every output, none in quiet stretches
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    function automatic logic [39:0] rand_args();
        return {8'($urandom), $urandom};
    endfunction

    // one request with a random lead-in gap; returns on the edge it is taken
    // and leaves tvalid high, so a following request can go back to back
    task automatic push_request(input logic [1:0] op, input logic [7:0] rx,
                                input logic [7:0] cmd, input logic [39:0] args);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {args, cmd, rx};
        do
            @(posedge clk);
        while (!s_tready);
        requests++;
    endtask

    task automatic tick_request();
        push_request(OP_TICK, 8'($urandom), 8'($urandom), rand_args());
    endtask

    task automatic rx_request(input logic [7:0] value);
        push_request(OP_RX, value, 8'($urandom), rand_args());
    endtask

    task automatic send_command(input logic [7:0] cmd, input logic [39:0] args);
        push_request(OP_SEND, 8'($urandom), cmd, args);
        commands++;
    endtask

    // drop tvalid and wait until every due output has been taken, then let
    // the engine settle in case the last requests produced nothing
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // setup cycle then access cycle; the extra edge keeps psel changes apart
    task automatic apb_access(input logic write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // register change only with the engine idle, read back for the checker
    task automatic set_timeout(input logic [15:0] value);
        wait_drained();
        apb_access(1'b1, {16'h0000, value});
        apb_access(1'b0, '0);
        timeout_now = value;
    endtask

    // reply to a command: random payload, range words 2000 and 5000 often,
    // a random fault (bad header, bad command, bad checksum, header and
    // checksum), optionally cut short and with stray ticks mixed in
    task automatic answer_command(input logic [7:0] cmd, input int keep,
                                  input bit stray_ticks);
        logic [7:0]  frame [FRAME_BYTES];
        logic [7:0]  sum;
        logic [15:0] lo;
        int          fault;
        frame[0] = HEADER_BYTE;
        frame[1] = cmd;
        for (int i = 2; i < 8; i++)
            frame[i] = 8'($urandom);
        case ($urandom_range(0, 3))
            0:       lo = RANGE_LOW;
            1:       lo = RANGE_HIGH;
            default: lo = {frame[4], frame[5]};
        endcase
        frame[4] = lo[15:8];
        frame[5] = lo[7:0];
        sum = '0;
        for (int i = 1; i < 8; i++)
            sum = sum + frame[i];
        frame[8] = 8'h00 - sum;
        fault = $urandom_range(0, 7);
        if (fault == 3 || fault == 6)
            frame[0] ^= 8'($urandom_range(1, 255));
        if (fault == 4)
            frame[1] ^= 8'($urandom_range(1, 255));
        if (fault >= 5)
            frame[8] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < keep; i++)
        begin
            if (stray_ticks && $urandom_range(0, 7) == 0)
                tick_request();
            rx_request(frame[i]);
        end
    endtask

    initial
    begin
        logic [7:0]  sample_reply [FRAME_BYTES];
        logic [15:0] phase_timeouts [4];
        logic [7:0]  cmd;
        logic [7:0]  next_cmd;
        int          picked;
        int          phase_start;

        // good reply to command 0x86: range 2000, flag set, checksum 0xa2
        sample_reply = '{8'hFF, 8'h86, 8'h00, 8'h00, 8'h07, 8'hD0, 8'h00, 8'h01, 8'hA2};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the register, then a short timeout for the directed part
        apb_access(1'b0, '0);
        set_timeout(16'd3);

        // not armed: unused op, tick and bytes all ignored
        push_request(OP_NONE, 8'hFF, 8'hFF, '1);
        tick_request();
        rx_request(8'h00);
        rx_request(HEADER_BYTE);

        // all-zero arguments, answered with a clean frame
        send_command(8'h86, '0);
        for (int i = 0; i < FRAME_BYTES; i++)
            rx_request(sample_reply[i]);

        // all-ones command and arguments, then a send while still armed
        send_command(8'hFF, '1);
        send_command(8'h00, rand_args());

        // the third tick times out even with a byte in between; the byte
        // after that finds the receiver disarmed
        tick_request();
        rx_request(HEADER_BYTE);
        tick_request();
        tick_request();
        rx_request(HEADER_BYTE);

        // random phases: reset value, shortest, a middling one, longest
        phase_timeouts[0] = TIMEOUT_RESET;
        phase_timeouts[1] = 16'd1;
        phase_timeouts[2] = 16'($urandom_range(2, 10));
        phase_timeouts[3] = TICK_MAX;
        for (int p = 0; p < 4; p++)
        begin
            set_timeout(phase_timeouts[p]);
            phase_start = requests;
            while (requests - phase_start < PHASE_LENGTH)
            begin
                quiet  = ($urandom_range(0, 3) == 0);
                picked = $urandom_range(0, 9);
                cmd    = 8'($urandom);
                if (picked <= 5)
                begin
                    // command and full reply, the bulk of the traffic
                    send_command(cmd, rand_args());
                    answer_command(cmd, FRAME_BYTES, 1'b1);
                end
                else if (picked == 6)
                begin
                    // no reply: wait it out where the timeout is short enough
                    send_command(cmd, rand_args());
                    if (timeout_now <= 40)
                        repeat (timeout_now) tick_request();
                    else
                    begin
                        repeat (3) tick_request();
                        answer_command(cmd, FRAME_BYTES, 1'b0);
                    end
                end
                else if (picked == 7)
                begin
                    // reply cut short by a new command
                    next_cmd = 8'($urandom);
                    send_command(cmd, rand_args());
                    answer_command(cmd, $urandom_range(1, FRAME_BYTES - 1), 1'b1);
                    send_command(next_cmd, rand_args());
                    answer_command(next_cmd, FRAME_BYTES, 1'b0);
                end
                else if (picked == 8)
                begin
                    // noise of any op with any fields
                    repeat ($urandom_range(1, 4))
                        push_request(2'($urandom_range(0, 3)), 8'($urandom),
                                     8'($urandom), rand_args());
                end
                else
                begin
                    // sender holds off until the engine has emptied
                    wait_drained();
                end
            end
        end

        // short timeout run to the end, back to back
        set_timeout(16'd5);
        quiet = 1'b1;
        send_command(8'($urandom), rand_args());
        repeat (timeout_now) tick_request();
        quiet = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        close_out <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d requests, %0d commands sent, %0d outputs checked",
                 requests, commands, outputs_seen);
        $display("timeouts 3, 100, 1, %0d, 65535, 5; good, faulty, cut and timed-out replies",
                 phase_timeouts[2]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sensor_command_frame_engine.f]
+incdir+hdl
hdl/scfe_pkg.sv
hdl/scfe_front.sv
hdl/scfe_queue.sv
hdl/scfe_back.sv
hdl/sensor_command_frame_engine.sv
tb/sv/scfe_frame_checker.sv
tb/sv/tb_top.sv
